>>> rtl/pcsc_pkg.sv
// shared types and constants for the pwm clock setting calculator
package pcsc_pkg;

    // configuration register
    localparam int RATE_W = 30;
    localparam logic [RATE_W-1:0] RATE_RESET = 30'd100000000;

    // counter width default and fixed limits
    localparam int COUNT_BITS_DEF = 16;
    localparam int MAX_PRESCALE = 256;
    localparam logic [2:0] MAX_DIV_CODE = 3'd7;
    localparam logic [31:0] NS_PER_S = 32'd1000000000;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_SAT   = 2'd1;
    localparam logic [1:0] ST_DUTY0 = 2'd2;
    localparam logic [1:0] ST_SHORT = 2'd3;

    // shared divider geometry: 33 quotient bits, 32-bit divisor
    localparam int DIV_DVD_W = 33;
    localparam int DIV_DVS_W = 32;
    localparam int DIV_STEPS = DIV_DVD_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // input beat
    typedef struct packed {
        logic [31:0] period_ns;
        logic [31:0] duty_ns;
        logic        inverted;
        logic        enable_request;
    } t_in;

    // result beat
    typedef struct packed {
        logic [15:0] clock_control_word;
        logic [15:0] period_count;
        logic [15:0] duty_count;
        logic        duty_written;
        logic        polarity_bit;
        logic        channel_enable;
        logic [1:0]  status;
    } t_out;

    // divider request: operands are taken when start is high and the divider is idle
    typedef struct packed {
        logic                 start;
        logic [DIV_DVS_W-1:0] rem_init;
        logic [DIV_DVD_W-1:0] dividend;
        logic [DIV_DVS_W-1:0] divisor;
    } t_div_req;

    // divider response: done pulses for one cycle, quotient holds after
    typedef struct packed {
        logic                 done;
        logic [DIV_DVD_W-1:0] quot;
    } t_div_rsp;

endpackage

>>> rtl/pcsc_div.sv
// shared restoring divider, one quotient bit per cycle
module pcsc_div
    import pcsc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_DVS_W-1:0] r_rem;
    logic [DIV_DVD_W-1:0] r_dvd;
    logic [DIV_DVS_W-1:0] r_dvs;

    logic [DIV_DVS_W:0]   w_rem_sh;
    logic [DIV_DVS_W:0]   w_diff;
    logic                 w_ge;

    // one shift-subtract step
    assign w_rem_sh = {r_rem, r_dvd[DIV_DVD_W-1]};
    assign w_ge     = w_rem_sh >= {1'b0, r_dvs};
    assign w_diff   = w_rem_sh - {1'b0, r_dvs};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: remainder, dividend shifting into quotient
    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_rem <= i_req.rem_init;
            r_dvd <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DIV_DVS_W-1:0] : w_rem_sh[DIV_DVS_W-1:0];
            r_dvd <= {r_dvd[DIV_DVD_W-2:0], w_ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_dvd;

endmodule

>>> rtl/pwm_clock_setting_calculator_unit.sv
// pwm clock setting calculator: sequencer, datapath and result register
//
//   channel  | signals                          | beat taken when
//   ---------+----------------------------------+---------------------------
//   input    | i_in_valid, o_in_ready, i_in_data | i_in_valid & o_in_ready
//   result   | o_out_valid, i_out_ready, o_out_data | o_out_valid & i_out_ready
//   config   | i_cfg_we, i_cfg_wdata            | i_cfg_we
//
// one beat at a time; the shared 33-step divider sets the pace, and a zero
// scaled period skips the prescale and period divisions.
// the divider code search tries one code per cycle, up to eight.
// reset is synchronous, active low, and sets the clock rate to 100 MHz.
// a finished result waits in the output register while the next beat runs;
// the next result then holds the sequencer until that register is free.
module pwm_clock_setting_calculator_unit
    import pcsc_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in               i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out              o_out_data,
    input  logic              i_cfg_we,
    input  logic [RATE_W-1:0] i_cfg_wdata
);

    // derived limits
    localparam logic [31:0] CNT_MAX   = 32'((64'd1 << COUNT_BITS) - 64'd1);
    localparam logic [40:0] SCALE_LIM = 41'(((64'd1 << COUNT_BITS) - 64'd1) << 8);

    // sequencer codes
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL_P = 4'd1;
    localparam logic [3:0] S_DIV_P = 4'd2;
    localparam logic [3:0] S_SEL   = 4'd3;
    localparam logic [3:0] S_PRE   = 4'd4;
    localparam logic [3:0] S_PRD   = 4'd5;
    localparam logic [3:0] S_MUL_D = 4'd6;
    localparam logic [3:0] S_DIV_D = 4'd7;
    localparam logic [3:0] S_DQ    = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    logic [3:0]        r_state;
    logic [3:0]        n_state;
    logic [RATE_W-1:0] r_rate;
    logic              r_go;
    logic              r_out_valid;
    t_out              r_out;

    logic [31:0]       r_period;
    logic [31:0]       r_duty;
    logic              r_inv;
    logic              r_en;
    logic              r_written;
    logic [61:0]       r_prod;
    logic [30:0]       r_scaled;
    logic [2:0]        r_dcode;
    logic [8:0]        r_presc;
    logic [15:0]       r_prd;
    logic [15:0]       r_duty_cnt;
    logic              r_duty_zero;
    logic              r_too_short;
    logic              r_sat;

    t_div_req          w_div_req;
    t_div_rsp          w_div_rsp;
    logic [31:0]       w_mul_b;
    logic              w_sel_ok;
    logic [32:0]       w_prd_raw;
    logic [32:0]       w_duty_m;
    logic [31:0]       w_dshift;
    logic              w_out_load;
    logic [1:0]        w_status;

    // shared divider
    pcsc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // divider operand select
    always_comb begin
        w_div_req.start = r_go;
        case (r_state)
            S_DIV_P, S_DIV_D: begin
                w_div_req.rem_init = 32'(r_prod[61:33]);
                w_div_req.dividend = r_prod[32:0];
                w_div_req.divisor  = NS_PER_S;
            end
            S_PRE: begin
                w_div_req.rem_init = '0;
                w_div_req.dividend = 33'(r_scaled) + 33'(CNT_MAX) - 33'd1;
                w_div_req.divisor  = CNT_MAX;
            end
            default: begin
                w_div_req.rem_init = '0;
                w_div_req.dividend = 33'(r_scaled);
                w_div_req.divisor  = 32'(r_presc);
            end
        endcase
    end

    // helpers
    assign w_mul_b    = (r_state == S_MUL_D) ? r_duty : r_period;
    assign w_sel_ok   = (41'(r_scaled) <= SCALE_LIM) || (r_dcode == MAX_DIV_CODE);
    assign w_prd_raw  = w_div_rsp.quot - 33'd1;
    assign w_duty_m   = w_div_rsp.quot & 33'(CNT_MAX);
    assign w_dshift   = w_div_rsp.quot[31:0] >> ({1'b0, r_dcode} + 4'd1);
    assign w_out_load = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    // status priority: too short, saturated, duty zero
    always_comb begin
        if (r_too_short) begin
            w_status = ST_SHORT;
        end else if (r_sat) begin
            w_status = ST_SAT;
        end else if (r_written && r_duty_zero) begin
            w_status = ST_DUTY0;
        end else begin
            w_status = ST_OK;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_MUL_P;
            S_MUL_P: n_state = S_DIV_P;
            S_DIV_P: if (w_div_rsp.done) n_state = S_SEL;
            S_SEL: begin
                if (w_sel_ok) begin
                    if (r_scaled == '0) begin
                        n_state = r_written ? S_MUL_D : S_OUT;
                    end else begin
                        n_state = S_PRE;
                    end
                end
            end
            S_PRE:   if (w_div_rsp.done) n_state = S_PRD;
            S_PRD: begin
                if (w_div_rsp.done) n_state = r_written ? S_MUL_D : S_OUT;
            end
            S_MUL_D: n_state = S_DIV_D;
            S_DIV_D: if (w_div_rsp.done) n_state = S_DQ;
            S_DQ:    if (w_div_rsp.done) n_state = S_OUT;
            S_OUT:   if (w_out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rate      <= RATE_RESET;
            r_go        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_rate <= i_cfg_wdata;
            // kick the divider on entry to a division state
            r_go <= ((r_state == S_MUL_P) || (r_state == S_MUL_D))
                 || ((r_state == S_SEL) && w_sel_ok && (r_scaled != '0))
                 || ((r_state == S_PRE) && w_div_rsp.done)
                 || ((r_state == S_DIV_D) && w_div_rsp.done);
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_period    <= i_in_data.period_ns;
                r_duty      <= i_in_data.duty_ns;
                r_inv       <= i_in_data.inverted;
                r_en        <= i_in_data.enable_request;
                r_written   <= (i_in_data.duty_ns != '0);
                r_duty_cnt  <= '0;
                r_duty_zero <= 1'b0;
            end
            S_MUL_P, S_MUL_D: begin
                r_prod <= 62'(r_rate) * 62'(w_mul_b);
            end
            S_DIV_P: begin
                if (w_div_rsp.done) begin
                    r_scaled <= w_div_rsp.quot[31:1];
                    r_dcode  <= '0;
                end
            end
            S_SEL: begin
                r_sat <= 1'b0;
                if (w_sel_ok) begin
                    r_too_short <= (r_scaled == '0);
                    r_presc     <= 9'd1;
                    r_prd       <= '0;
                end else begin
                    r_scaled <= r_scaled >> 1;
                    r_dcode  <= r_dcode + 3'd1;
                end
            end
            S_PRE: begin
                if (w_div_rsp.done) begin
                    if (w_div_rsp.quot > 33'(MAX_PRESCALE)) begin
                        r_presc <= 9'(MAX_PRESCALE);
                        r_sat   <= 1'b1;
                    end else begin
                        r_presc <= w_div_rsp.quot[8:0];
                    end
                end
            end
            S_PRD: begin
                if (w_div_rsp.done) begin
                    r_prd <= 16'((w_prd_raw > 33'(CNT_MAX)) ? 33'(CNT_MAX) : w_prd_raw);
                end
            end
            S_DIV_D: begin
                if (w_div_rsp.done) r_scaled <= w_dshift[30:0];
            end
            S_DQ: begin
                if (w_div_rsp.done) begin
                    r_duty_cnt  <= 16'(w_duty_m);
                    r_duty_zero <= (w_duty_m == '0);
                end
            end
            default: begin
            end
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out.clock_control_word <= {8'(r_presc - 9'd1), 1'b0, r_dcode, 4'b0000};
            r_out.period_count       <= r_prd;
            r_out.duty_count         <= r_duty_cnt;
            r_out.duty_written       <= r_written;
            r_out.polarity_bit       <= r_inv;
            r_out.channel_enable     <= r_en;
            r_out.status             <= w_status;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    // divider finishes only while a division state waits for it
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_state == S_DIV_P || r_state == S_PRE ||
                            r_state == S_PRD || r_state == S_DIV_D || r_state == S_DQ))
        else $error("divider done outside a division state");

    // an accepted beat drops ready until its result is built
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready stayed high after an input beat");

    // result register fills only from the final state
    a_load_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_OUT))
        else $error("result valid without a finished beat");

    // prescale stays in range while counts are divided by it
    a_presc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PRD || r_state == S_DQ) |-> (r_presc != '0 && r_presc <= 9'd256))
        else $error("prescale out of range");
`endif

endmodule

>>> bench/testbench.sv
// testbench for the pwm clock setting calculator: directed and random beats
`timescale 1ns / 100ps

module testbench
    import pcsc_pkg::*;
();

    localparam int COUNT_BITS = COUNT_BITS_DEF;
    localparam logic [63:0] COUNT_MAX = (64'd1 << COUNT_BITS) - 64'd1;
    localparam logic [63:0] SCALED_LIMIT = COUNT_MAX * 64'd256;
    localparam logic [RATE_W-1:0] RATE_FASTEST = {RATE_W{1'b1}};
    localparam logic [RATE_W-1:0] RATE_1GHZ = 30'd1000000000;
    localparam logic [RATE_W-1:0] RATE_ZERO = '0;
    localparam logic [RATE_W-1:0] RATE_SLOWEST = 30'd1;
    localparam int HOLD_OFF_CYCLES = 600;
    localparam int RANDOM_PER_PHASE = 140;
    localparam int BACKPRESSURE_BEATS = 16;
    localparam int SETTLE_CYCLES = 250;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    t_in               i_in_data = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    t_out              o_out_data;
    logic              i_cfg_we = 1'b0;
    logic [RATE_W-1:0] i_cfg_wdata = '0;

    // predictor state and scoreboard
    logic [RATE_W-1:0] clock_rate = RATE_RESET;
    t_out expected_settings[$];
    int mismatch_count = 0;
    int beats_sent = 0;
    int rate_settings = 1;
    int status_seen[4] = '{0, 0, 0, 0};

    // idling and hold-off control
    int sender_idle_pct = 0;
    int out_stall_pct = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;

    pwm_clock_setting_calculator_unit #(
        .COUNT_BITS (COUNT_BITS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // nanoseconds to source clock cycles, truncated to 32 bits
    function automatic logic [31:0] ns_to_cycles(logic [31:0] ns, logic [RATE_W-1:0] rate);
        logic [63:0] prod;
        prod = 64'(rate) * 64'(ns);
        return 32'(prod / 64'(NS_PER_S));
    endfunction

    // expected counter settings for one request beat
    function automatic t_out calc_pwm_setting(t_in beat, logic [RATE_W-1:0] rate);
        logic [63:0] period_cyc;
        logic [63:0] duty_cyc;
        logic [63:0] scaled;
        logic [63:0] prescale;
        logic [63:0] period_cnt;
        logic [63:0] duty_cnt;
        int code;
        logic too_short;
        logic prescale_sat;
        logic written;
        t_out res;
        period_cyc = 64'(ns_to_cycles(beat.period_ns, rate));
        // smallest divider code that fits, stuck at the top code
        code = 0;
        scaled = period_cyc >> 1;
        while (scaled > SCALED_LIMIT && code < int'(MAX_DIV_CODE)) begin
            code++;
            scaled = period_cyc >> (code + 1);
        end
        too_short = (scaled == 0);
        prescale_sat = 1'b0;
        written = (beat.duty_ns != 0);
        if (too_short) begin
            prescale = 1;
            period_cnt = 0;
        end else begin
            prescale = (scaled + COUNT_MAX - 1) / COUNT_MAX;
            if (prescale > MAX_PRESCALE) begin
                prescale = MAX_PRESCALE;
                prescale_sat = 1'b1;
            end
            period_cnt = scaled / prescale - 1;
            if (period_cnt > COUNT_MAX) begin
                period_cnt = COUNT_MAX;
            end
        end
        duty_cnt = 0;
        if (written) begin
            duty_cyc = 64'(ns_to_cycles(beat.duty_ns, rate));
            duty_cnt = ((duty_cyc >> (code + 1)) / prescale) & COUNT_MAX;
        end
        res.clock_control_word = 16'(((prescale - 1) << 8) | (64'(code) << 4));
        res.period_count = 16'(period_cnt);
        res.duty_count = 16'(duty_cnt);
        res.duty_written = written;
        res.polarity_bit = beat.inverted;
        res.channel_enable = beat.enable_request;
        if (too_short) begin
            res.status = ST_SHORT;
        end else if (prescale_sat) begin
            res.status = ST_SAT;
        end else if (written && duty_cnt == 0) begin
            res.status = ST_DUTY0;
        end else begin
            res.status = ST_OK;
        end
        return res;
    endfunction

    function automatic t_in make_beat(logic [31:0] period, logic [31:0] duty, logic inv, logic en);
        t_in b;
        b.period_ns = period;
        b.duty_ns = duty;
        b.inverted = inv;
        b.enable_request = en;
        return b;
    endfunction

    // random request with periods spread over all magnitudes
    function automatic t_in random_beat();
        t_in b;
        case ($urandom_range(9))
            0, 1, 2: b.period_ns = $urandom;
            3, 4, 5: b.period_ns = $urandom >> $urandom_range(31);
            6:       b.period_ns = $urandom_range(200);
            7:       b.period_ns = 32'hFFFF_FFFF - $urandom_range(70000);
            default: b.period_ns = $urandom >> $urandom_range(24, 8);
        endcase
        case ($urandom_range(3))
            0:       b.duty_ns = '0;
            1:       b.duty_ns = $urandom;
            default: b.duty_ns = b.period_ns >> $urandom_range(6);
        endcase
        b.inverted = 1'($urandom);
        b.enable_request = 1'($urandom);
        return b;
    endfunction

    // offer one beat, wait for the handshake and log its expected result
    task automatic send_beat(input t_in beat);
        if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < sender_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in_data <= beat;
        do @(posedge i_clk); while (!o_in_ready);
        expected_settings.push_back(calc_pwm_setting(beat, clock_rate));
        beats_sent++;
    endtask

    task automatic stop_sending();
        i_in_valid <= 1'b0;
    endtask

    task automatic wait_drain();
        while (expected_settings.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // register write once the block has gone quiet
    task automatic write_rate(input logic [RATE_W-1:0] rate);
        wait_drain();
        repeat (4) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= rate;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        clock_rate = rate;
        rate_settings++;
    endtask

    task automatic set_idling(input t_idle_mode mode);
        case (mode)
            IDLE_NONE: begin
                sender_idle_pct = 0;
                out_stall_pct = 0;
            end
            IDLE_SENDER: begin
                sender_idle_pct = 60;
                out_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                sender_idle_pct = 0;
                out_stall_pct = 60;
            end
            default: begin
                sender_idle_pct = 20;
                out_stall_pct = 20;
            end
        endcase
    endtask

    // result side ready, with long hold-offs on request
    always @(posedge i_clk) begin
        if (hold_requests != hold_served) begin
            hold_served <= hold_served + 1;
            hold_left <= HOLD_OFF_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= out_stall_pct);
        end
    end

    task automatic check_setting(input t_out want, input t_out got);
        logic ok;
        ok = (got.clock_control_word === want.clock_control_word)
            && (got.period_count === want.period_count)
            && (got.duty_count === want.duty_count)
            && (got.duty_written === want.duty_written)
            && (got.polarity_bit === want.polarity_bit)
            && (got.channel_enable === want.channel_enable)
            && (got.status === want.status);
        status_seen[want.status]++;
        if (!ok) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("mismatch at %0t: expected ccw %h prd %h duty %h dw %b pol %b en %b st %0d",
                         $realtime, want.clock_control_word, want.period_count,
                         want.duty_count, want.duty_written, want.polarity_bit,
                         want.channel_enable, want.status);
                $display("                   got ccw %h prd %h duty %h dw %b pol %b en %b st %0d",
                         got.clock_control_word, got.period_count, got.duty_count,
                         got.duty_written, got.polarity_bit, got.channel_enable, got.status);
            end
        end
    endtask

    // result beat checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_settings.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected result at %0t: ccw %h prd %h duty %h st %0d", $realtime,
                             o_out_data.clock_control_word, o_out_data.period_count,
                             o_out_data.duty_count, o_out_data.status);
                end
            end else begin
                check_setting(expected_settings.pop_front(), o_out_data);
            end
        end
    end

    // corner requests at the reset clock rate of 100 MHz
    task automatic test_reset_rate_corners();
        set_idling(IDLE_NONE);
        send_beat(make_beat(32'd0, 32'd0, 1'b0, 1'b0));
        send_beat(make_beat(32'd0, 32'hFFFF_FFFF, 1'b1, 1'b1));
        send_beat(make_beat(32'd10, 32'd5, 1'b0, 1'b1));
        send_beat(make_beat(32'd20, 32'd20, 1'b1, 1'b0));
        send_beat(make_beat(32'd1000, 32'd1, 1'b0, 1'b0));
        // prescale steps from 1 to 2
        send_beat(make_beat(32'd1310700, 32'd655350, 1'b1, 1'b1));
        send_beat(make_beat(32'd1310720, 32'd1, 1'b0, 1'b1));
        // divider code boundary, on and just past it
        send_beat(make_beat(32'd335539200, 32'd167769600, 1'b0, 1'b1));
        send_beat(make_beat(32'd335539220, 32'd0, 1'b1, 1'b0));
        send_beat(make_beat(32'd1000, 32'hFFFF_FFFF, 1'b1, 1'b1));
        send_beat(make_beat(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0));
        send_beat(make_beat(32'd20000000, 32'd10000000, 1'b1, 1'b1));
        stop_sending();
    endtask

    // periods too long for any divider code at 1 GHz, and one just short enough
    task automatic test_prescale_saturation();
        write_rate(RATE_1GHZ);
        send_beat(make_beat(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0));
        send_beat(make_beat(32'd4294902016, 32'd0, 1'b0, 1'b1));
        send_beat(make_beat(32'd4294902015, 32'd1000, 1'b1, 1'b1));
        stop_sending();
    endtask

    // zero clock rate gives zero cycles everywhere
    task automatic test_zero_rate();
        write_rate(RATE_ZERO);
        send_beat(make_beat(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1));
        send_beat(make_beat(32'd12345, 32'd0, 1'b0, 1'b0));
        stop_sending();
    endtask

    task automatic test_rate_extremes();
        write_rate(RATE_SLOWEST);
        send_beat(make_beat(32'hFFFF_FFFF, 32'h8000_0000, 1'b0, 1'b1));
        send_beat(make_beat(32'd2000000000, 32'd0, 1'b1, 1'b0));
        stop_sending();
        // cycle counts wrap at 32 bits
        write_rate(RATE_FASTEST);
        send_beat(make_beat(32'hFFFF_FFFF, 32'd1, 1'b1, 1'b1));
        send_beat(make_beat(32'd2147483648, 32'hFFFF_FFFF, 1'b0, 1'b0));
        stop_sending();
    endtask

    // random beats over several clock rates and idling patterns
    task automatic test_random_rates();
        logic [RATE_W-1:0] rates[6];
        t_idle_mode modes[6];
        rates[0] = RATE_RESET;
        rates[1] = RATE_1GHZ;
        rates[2] = RATE_FASTEST;
        rates[3] = RATE_W'($urandom);
        rates[4] = RATE_W'($urandom_range(200000000, 1000000));
        rates[5] = RATE_W'($urandom_range(1000000000, 1));
        modes = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH, IDLE_SENDER, IDLE_RECEIVER};
        for (int p = 0; p < 6; p++) begin
            write_rate(rates[p]);
            set_idling(modes[p]);
            repeat (RANDOM_PER_PHASE) send_beat(random_beat());
            stop_sending();
        end
    endtask

    // receiver holds off while the sender keeps offering, so the input stalls
    task automatic test_backpressure();
        write_rate(RATE_W'($urandom_range(1000000000, 1000000)));
        set_idling(IDLE_NONE);
        hold_requests <= hold_requests + 1;
        repeat (BACKPRESSURE_BEATS) send_beat(random_beat());
        stop_sending();
        // sender pauses until everything has come back
        wait_drain();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_rate_corners();
        test_prescale_saturation();
        test_zero_rate();
        test_rate_extremes();
        test_random_rates();
        test_backpressure();

        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d beats over %0d clock rate settings, with idling and hold-off",
                 beats_sent, rate_settings);
        $display("results by status: ok %0d, prescale saturated %0d, duty zero %0d, short %0d",
                 status_seen[ST_OK], status_seen[ST_SAT], status_seen[ST_DUTY0],
                 status_seen[ST_SHORT]);
        if (mismatch_count == 0 && expected_settings.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // run limit
    initial begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
